/* sv/fpsm_pkg.sv */
// Shared types and constants for the frame interval averager / fps meter.
// Holds window sizing, op codes and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none
package fpsm_pkg;

    localparam int WINDOW_SIZE = 64;
    localparam int IDX_W       = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
    localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);
    localparam int SUM_W       = 32 + $clog2(WINDOW_SIZE);
    localparam int DIV_CNT_W   = $clog2(SUM_W);

    localparam logic [31:0] TPS_RESET = 32'd10000000;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_RESET = 2'd3
    } t_op;

    typedef struct packed {
        logic capture;
        logic exec;
        logic win_rd;
        logic win_upd;
        logic div_start;
        logic avg_load;
        logic tot_a;
        logic tot_b;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic tick_run;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

/* sv/fpsm_div.sv */
// Restoring divider, one quotient bit per cycle, for the window average.
// Depends on fpsm_pkg for the sum and count widths.
`default_nettype none
module fpsm_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [fpsm_pkg::SUM_W-1:0] i_dividend,
    input  wire logic [fpsm_pkg::CNT_W-1:0] i_divisor,
    output logic                           o_done,
    output logic [fpsm_pkg::SUM_W-1:0]     o_quotient
);
    import fpsm_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]     r_quo;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_dsr;
    logic [CNT_W:0]       trial;
    logic                 q_bit;
    logic [CNT_W-1:0]     n_rem;

    always_comb begin
        trial = {r_rem, r_quo[SUM_W-1]};
        q_bit = (trial >= {1'b0, r_dsr});
        n_rem = q_bit ? CNT_W'(trial - {1'b0, r_dsr}) : trial[CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

/* sv/fpsm_ctrl.sv */
// Sequencing state machine for one item: op update, window update and divide (running ticks only), totals, result.
// Depends on fpsm_pkg for the command and status structs.
`default_nettype none
module fpsm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire fpsm_pkg::t_sts i_sts,
    output fpsm_pkg::t_cmd      o_cmd,
    output logic                o_idle
);
    import fpsm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_WRD,
        S_WUPD,
        S_DGO,
        S_DWAIT,
        S_TOT1,
        S_TOT2,
        S_FIN
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE:  if (i_in_valid) r_state <= S_EXEC;
                S_EXEC:  r_state <= i_sts.tick_run ? S_WRD : S_TOT1;
                S_WRD:   r_state <= S_WUPD;
                S_WUPD:  r_state <= S_DGO;
                S_DGO:   r_state <= S_DWAIT;
                S_DWAIT: if (i_sts.div_done) r_state <= S_TOT1;
                S_TOT1:  r_state <= S_TOT2;
                S_TOT2:  r_state <= S_FIN;
                S_FIN:   if (i_sts.out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.capture   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec      = (r_state == S_EXEC);
        o_cmd.win_rd    = (r_state == S_WRD);
        o_cmd.win_upd   = (r_state == S_WUPD);
        o_cmd.div_start = (r_state == S_DGO);
        o_cmd.avg_load  = (r_state == S_DWAIT) && i_sts.div_done;
        o_cmd.tot_a     = (r_state == S_TOT1);
        o_cmd.tot_b     = (r_state == S_TOT2);
        o_cmd.out_load  = (r_state == S_FIN) && i_sts.out_free;
    end

    assign o_idle = (r_state == S_IDLE);

endmodule
`default_nettype wire

/* sv/fpsm_dp.sv */
// Datapath: timer stamps, interval window memory, rate counter, totals and result register.
// Depends on fpsm_pkg and instantiates fpsm_div.
`default_nettype none
module fpsm_dp (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire fpsm_pkg::t_cmd i_cmd,
    output fpsm_pkg::t_sts      o_sts,
    input  wire logic [1:0]     i_op,
    input  wire logic [63:0]    i_timestamp,
    input  wire logic           i_cfg_we,
    input  wire logic [31:0]    i_cfg_data,
    input  wire logic           i_out_stall,
    output logic                o_out_valid,
    output logic [31:0]         o_avg_frame_ticks,
    output logic [15:0]         o_frame_rate,
    output logic [63:0]         o_total_ticks,
    output logic                o_is_stopped
);
    import fpsm_pkg::*;

    logic [31:0]            r_tps;
    t_op                    r_op;
    logic [63:0]            r_stamp;
    logic [63:0]            r_last;
    logic [63:0]            r_base;
    logic [63:0]            r_stop;
    logic [63:0]            r_paused;
    logic [63:0]            r_latest;
    logic                   r_stopped;
    logic [31:0]            r_interval;
    logic                   r_accept;
    logic [31:0]            r_win [WINDOW_SIZE];
    logic [WINDOW_SIZE-1:0] r_wvalid;
    logic [31:0]            r_old;
    logic                   r_old_vld;
    logic [SUM_W-1:0]       r_sum;
    logic [IDX_W-1:0]       r_head;
    logic [CNT_W-1:0]       r_count;
    logic [31:0]            r_avg;
    logic [15:0]            r_frames;
    logic [63:0]            r_accum;
    logic [15:0]            r_rate;
    logic [63:0]            r_tot;
    logic                   r_out_valid;

    logic [63:0]            delta;
    logic [31:0]            n_interval;
    logic [31:0]            diff;
    logic [31:0]            old_val;
    logic [15:0]            n_frames;
    logic [63:0]            n_accum;
    logic                   div_done;
    logic [SUM_W-1:0]       quotient;

    always_comb begin
        delta      = r_stamp - r_last;
        n_interval = (|delta[63:32]) ? 32'hFFFF_FFFF : delta[31:0];
        diff       = (r_interval >= r_avg) ? (r_interval - r_avg) : (r_avg - r_interval);
        old_val    = r_old_vld ? r_old : 32'd0;
        n_frames   = (r_frames != 16'hFFFF) ? (r_frames + 16'd1) : r_frames;
        n_accum    = r_accum + {32'd0, r_interval};
    end

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps       <= TPS_RESET;
            r_last      <= '0;
            r_base      <= '0;
            r_stop      <= '0;
            r_paused    <= '0;
            r_latest    <= '0;
            r_stopped   <= 1'b0;
            r_wvalid    <= '0;
            r_sum       <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_avg       <= '0;
            r_frames    <= '0;
            r_accum     <= '0;
            r_rate      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_tps <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                case (r_op)
                    OP_TICK: begin
                        if (r_stopped) begin
                            r_avg <= '0;
                        end else begin
                            r_last   <= r_stamp;
                            r_latest <= r_stamp;
                        end
                    end
                    OP_START: begin
                        if (r_stopped) begin
                            r_paused  <= r_paused + r_stamp - r_stop;
                            r_last    <= r_stamp;
                            r_stop    <= '0;
                            r_stopped <= 1'b0;
                        end
                    end
                    OP_STOP: begin
                        if (!r_stopped) begin
                            r_stop    <= r_stamp;
                            r_stopped <= 1'b1;
                        end
                    end
                    default: begin
                        r_base    <= r_stamp;
                        r_last    <= r_stamp;
                        r_stop    <= '0;
                        r_stopped <= 1'b0;
                    end
                endcase
            end
            if (i_cmd.win_upd) begin
                if (r_accept) begin
                    r_sum            <= r_sum - SUM_W'(old_val) + SUM_W'(r_interval);
                    r_wvalid[r_head] <= 1'b1;
                    r_head           <= (r_head == IDX_W'(WINDOW_SIZE - 1)) ?
                                        '0 : r_head + 1'b1;
                    if (r_count < CNT_W'(WINDOW_SIZE)) begin
                        r_count <= r_count + 1'b1;
                    end
                end
                if (n_accum > {32'd0, r_tps}) begin
                    r_rate   <= n_frames;
                    r_frames <= '0;
                    r_accum  <= '0;
                end else begin
                    r_frames <= n_frames;
                    r_accum  <= n_accum;
                end
            end
            if (i_cmd.avg_load) begin
                r_avg <= (r_count == '0) ? 32'd0 : quotient[31:0];
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= t_op'(i_op);
            r_stamp <= i_timestamp;
        end
        if (i_cmd.exec) begin
            r_interval <= n_interval;
        end
        if (i_cmd.win_rd) begin
            r_accept <= (diff < r_tps);
        end
        if (i_cmd.tot_a) begin
            r_tot <= (r_stopped ? r_stop : r_latest) - r_paused;
        end
        if (i_cmd.tot_b) begin
            r_tot <= r_tot - r_base;
        end
        if (i_cmd.out_load) begin
            o_avg_frame_ticks <= r_avg;
            o_frame_rate      <= r_rate;
            o_total_ticks     <= r_tot;
            o_is_stopped      <= r_stopped;
        end
    end

    // Window memory: one registered read, one write.
    always_ff @(posedge i_clk) begin
        if (i_cmd.win_rd) begin
            r_old     <= r_win[r_head];
            r_old_vld <= r_wvalid[r_head];
        end
        if (i_cmd.win_upd && r_accept) begin
            r_win[r_head] <= r_interval;
        end
    end

    fpsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_comb begin
        o_sts          = '0;
        o_sts.tick_run = (r_op == OP_TICK) && !r_stopped;
        o_sts.div_done = div_done;
        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

/* sv/frame_interval_averager_fps_meter_core.sv */
// Top level of the frame interval averager and frame-rate meter.
// Depends on fpsm_pkg; instantiates fpsm_ctrl and fpsm_dp (which holds fpsm_div).
//
// Usage:
//   Input channel (i_in_valid / o_in_stall): one beat per event, op plus timestamp sample.
//   Output channel (o_out_valid / i_out_stall): one result beat per input beat, in order:
//   average frame interval, frames in the last completed second, running time minus
//   paused time, and the stopped flag.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): writes ticks_per_second;
//   write it only while no beat is in flight.
// Processing steps:
//   A tick while running raises o_out_valid after op update, window read and compare,
//   window/rate update, divider start, the shift steps of the divide plus its done
//   step, and two 64-bit subtract steps for the total. Other ops go through op update,
//   the two subtract steps and the result step. One beat is in work at a time, so a new
//   beat is taken only once the last one's result is loaded; the divider sets the tick rate.
// Reset (synchronous, active low) clears all timer state, the rate counters and the
//   window valid bits and loads 10,000,000 ticks per second; input and config stall.
// Back-pressure: the result register holds a beat while i_out_stall is high; the next
//   beat is accepted and processed meanwhile and waits only at its final step.
`default_nettype none
module frame_interval_averager_fps_meter_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [63:0] i_timestamp,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_avg_frame_ticks,
    output logic [15:0]      o_frame_rate,
    output logic [63:0]      o_total_ticks,
    output logic             o_is_stopped,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_cfg_data
);
    import fpsm_pkg::*;

    t_cmd cmd;
    t_sts sts;
    logic ctrl_idle;

    // Hold off input while an item is in work or reset is asserted.
    assign o_in_stall  = !i_rst_n || !ctrl_idle;
    assign o_cfg_ready = i_rst_n;

    fpsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_idle     (ctrl_idle)
    );

    fpsm_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_op              (i_op),
        .i_timestamp       (i_timestamp),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_avg_frame_ticks (o_avg_frame_ticks),
        .o_frame_rate      (o_frame_rate),
        .o_total_ticks     (o_total_ticks),
        .o_is_stopped      (o_is_stopped)
    );

    // An accepted beat makes the block busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted but block not busy next cycle");

    // A new result is loaded only when the result register is free.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("result register overwritten while stalled");

    // A result appears only at the end of work, never from the idle state.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result raised without an item in work");

    // Divider completion only arrives while the datapath is busy with a tick.
    a_div_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.div_done |-> o_in_stall)
        else $error("divider finished while idle");

endmodule
`default_nettype wire
